/* sv/cramer_rule_linear_solver_core_defines.svh */
// assertion macros for the cramer rule solver
`ifndef CRAMER_RULE_LINEAR_SOLVER_CORE_DEFINES_SVH
`define CRAMER_RULE_LINEAR_SOLVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CRLS_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crls assertion failed");
`define CRLS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crls assertion failed");
`else
`define CRLS_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define CRLS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* sv/crls_pkg.sv */
// shared types and constants of the cramer rule solver
`timescale 1ns / 1ps
package crls_pkg;

  localparam int DET_W      = 64;
  localparam int SOL_W      = 48;
  localparam int PERM_COUNT = 24;
  localparam int PERM_N     = 4;

  // column picked in each row, row 0 in the low bits
  localparam logic [7:0] PERM_TBL [PERM_COUNT] = '{
    {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
    {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
    {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
    {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
    {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
    {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
    {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
    {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
    {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
    {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
    {2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
    {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
  };

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DET  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [SOL_W-1:0] solution;
    logic             saturated;
  } div_res_t;

endpackage

/* sv/crls_div.sv */
// restoring divider giving a saturated signed fixed point quotient
`timescale 1ns / 1ps
module crls_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [crls_pkg::DET_W-1:0]   num_i,
  input  logic signed [crls_pkg::DET_W-1:0]   den_i,
  output logic                                done_o,
  output crls_pkg::div_res_t                  res_o
);
  import crls_pkg::*;

  localparam int DVD_W = DET_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DET_W:0]   rem_q, rem_d, rem_sh;
  logic [DET_W-1:0] den_q, den_d;
  logic [SOL_W:0]   quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DET_W-1:0] num_mag, den_mag;
  logic             ge;
  logic [SOL_W-1:0] limit, mag;
  logic             sat;

  assign num_mag = num_i[DET_W-1] ? DET_W'(-num_i) : DET_W'(num_i);
  assign den_mag = den_i[DET_W-1] ? DET_W'(-den_i) : DET_W'(den_i);
  assign rem_sh  = {rem_q[DET_W-1:0], dvd_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = DVD_W'(num_mag) << FRACTION_BITS;
      rem_d  = '0;
      den_d  = den_mag;
      quo_d  = '0;
      ovf_d  = 1'b0;
      neg_d  = num_i[DET_W-1] ^ den_i[DET_W-1];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      rem_d = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_d = {quo_q[SOL_W-1:0], ge};
      ovf_d = ovf_q | quo_q[SOL_W];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
  end

  assign limit = neg_q ? {1'b1, {(SOL_W-1){1'b0}}} : {1'b0, {(SOL_W-1){1'b1}}};
  assign sat   = ovf_q | (quo_q > {1'b0, limit});
  assign mag   = sat ? limit : quo_q[SOL_W-1:0];

  assign done_o             = done_q;
  assign res_o.saturated    = sat;
  assign res_o.solution     = neg_q ? -mag : mag;

endmodule

/* sv/cramer_rule_linear_solver_core.sv */
// cramer rule solver top: stores, determinant sequencer and output register
//
// channel  dir  handshake                 word
// in       in   in_valid_i / in_ready_o   row, col, rhs flag, value, last
// out      out  out_valid_o / out_ready_i unknown index, solution, flags
// cfg      in   cfg_valid_i / cfg_ready_o system size
//
// a word with last starts a solve
// each determinant is 24 permutation products on one shared multiplier
// each unknown's determinant is then divided by the system determinant in the bit serial divider
// input is not ready from the start of a solve until its last result word is taken
`timescale 1ns / 1ps
`include "cramer_rule_linear_solver_core_defines.svh"
module cramer_rule_linear_solver_core #(
  parameter int MAX_UNKNOWNS  = 4,
  parameter int VALUE_BITS    = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        row_index_i,
  input  logic [1:0]                        col_index_i,
  input  logic                              is_rhs_i,
  input  logic signed [11:0]                value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        unknown_index_o,
  output logic signed [crls_pkg::SOL_W-1:0] solution_o,
  output logic                              singular_o,
  output logic                              saturated_o,
  output logic                              last_result_o
);
  import crls_pkg::*;

  localparam int IDX_W  = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
  localparam int PROD_W = PERM_N * VALUE_BITS;
  localparam int MUL_W  = PROD_W + VALUE_BITS;

  logic signed [VALUE_BITS-1:0] coef_q [MAX_UNKNOWNS][MAX_UNKNOWNS];
  logic signed [VALUE_BITS-1:0] rhs_q  [MAX_UNKNOWNS];

  state_e                   state_q, state_d;
  logic [2:0]               size_q;
  logic [2:0]               nsel;
  logic [4:0]               perm_q, perm_d;
  logic [2:0]               row_q, row_d;
  logic                     sub_q, sub_d;
  logic [1:0]               col_q, col_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DET_W-1:0]  acc_q, acc_d;
  logic signed [DET_W-1:0]  det_q, det_d;
  logic signed [DET_W-1:0]  prod_ext;

  logic                     ov_q, ov_d;
  logic [1:0]               ou_q, ou_d;
  logic [SOL_W-1:0]         os_q, os_d;
  logic                     osing_q, osing_d;
  logic                     osat_q, osat_d;
  logic                     olast_q, olast_d;

  logic                     in_acc, out_acc;
  logic [1:0]               r, c;
  logic                     in_sys;
  logic signed [VALUE_BITS-1:0] elem;
  logic signed [MUL_W-1:0]  mul_full;
  logic                     div_start, div_done;
  div_res_t                 div_res;
  logic                     col_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = ov_q && out_ready_i;

  assign nsel = (size_q == 3'd0) ? 3'd1 :
                (size_q > 3'(MAX_UNKNOWNS)) ? 3'(MAX_UNKNOWNS) : size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 3'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (is_rhs_i) begin
        if ({1'b0, row_index_i} < 3'(MAX_UNKNOWNS)) begin
          rhs_q[row_index_i[IDX_W-1:0]] <= value_i[VALUE_BITS-1:0];
        end
      end else if (({1'b0, row_index_i} < 3'(MAX_UNKNOWNS)) &&
                   ({1'b0, col_index_i} < 3'(MAX_UNKNOWNS))) begin
        coef_q[row_index_i[IDX_W-1:0]][col_index_i[IDX_W-1:0]] <=
          value_i[VALUE_BITS-1:0];
      end
    end
  end

  // entries outside the active system act as the identity
  assign r      = row_q[1:0];
  assign c      = PERM_TBL[perm_q][2*r +: 2];
  assign in_sys = ({1'b0, r} < nsel) && ({1'b0, c} < nsel);

  always_comb begin
    if (in_sys) begin
      if (sub_q && (c == col_q)) begin
        elem = rhs_q[r[IDX_W-1:0]];
      end else begin
        elem = coef_q[r[IDX_W-1:0]][c[IDX_W-1:0]];
      end
    end else begin
      elem = (r == c) ? VALUE_BITS'(1) : '0;
    end
  end

  assign mul_full = prod_q * elem;
  assign prod_ext = {{(DET_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign col_last = ({1'b0, col_q} == nsel - 3'd1);

  always_comb begin
    state_d   = state_q;
    perm_d    = perm_q;
    row_d     = row_q;
    sub_d     = sub_q;
    col_d     = col_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    det_d     = det_q;
    ov_d      = ov_q;
    ou_d      = ou_q;
    os_d      = os_q;
    osing_d   = osing_q;
    osat_d    = osat_q;
    olast_d   = olast_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && last_i) begin
          acc_d   = '0;
          perm_d  = '0;
          row_d   = '0;
          sub_d   = 1'b0;
          col_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (row_q < 3'(PERM_N)) begin
          prod_d = (row_q == 3'd0) ? PROD_W'(elem) : mul_full[PROD_W-1:0];
          row_d  = row_q + 3'd1;
        end else begin
          acc_d = (perm_q[0] ^ perm_q[1]) ? acc_q - prod_ext : acc_q + prod_ext;
          row_d = '0;
          if (perm_q == 5'(PERM_COUNT - 1)) begin
            state_d = S_DET;
          end else begin
            perm_d = perm_q + 5'd1;
          end
        end
      end
      S_DET: begin
        if (sub_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          det_d = acc_q;
          if (acc_q == '0) begin
            ov_d    = 1'b1;
            ou_d    = '0;
            os_d    = '0;
            osing_d = 1'b1;
            osat_d  = 1'b0;
            olast_d = 1'b1;
            state_d = S_OUT;
          end else begin
            sub_d   = 1'b1;
            col_d   = '0;
            acc_d   = '0;
            perm_d  = '0;
            row_d   = '0;
            state_d = S_MUL;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          ov_d    = 1'b1;
          ou_d    = col_q;
          os_d    = div_res.solution;
          osing_d = 1'b0;
          osat_d  = div_res.saturated;
          olast_d = col_last;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          ov_d = 1'b0;
          if (olast_q) begin
            state_d = S_IDLE;
          end else begin
            col_d   = col_q + 2'd1;
            acc_d   = '0;
            perm_d  = '0;
            row_d   = '0;
            state_d = S_MUL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        ov_d    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      perm_q  <= '0;
      row_q   <= '0;
      sub_q   <= 1'b0;
      col_q   <= '0;
      det_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      perm_q  <= perm_d;
      row_q   <= row_d;
      sub_q   <= sub_d;
      col_q   <= col_d;
      det_q   <= det_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    ou_q    <= ou_d;
    os_q    <= os_d;
    osing_q <= osing_d;
    osat_q  <= osat_d;
    olast_q <= olast_d;
  end

  crls_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (acc_q),
    .den_i  (det_q),
    .done_o (div_done),
    .res_o  (div_res)
  );

  assign out_valid_o     = ov_q;
  assign unknown_index_o = ou_q;
  assign solution_o      = os_q;
  assign singular_o      = osing_q;
  assign saturated_o     = osat_q;
  assign last_result_o   = olast_q;

  `CRLS_ASSERT_IMPLY(a_singular_is_last, clk_i, rst_ni, out_valid_o && singular_o, last_result_o && !saturated_o)
  `CRLS_ASSERT_IMPLY(a_idle_no_result, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `CRLS_ASSERT_IMPLY(a_last_index, clk_i, rst_ni, out_valid_o && !singular_o && last_result_o, {1'b0, unknown_index_o} == nsel - 3'd1)
  `CRLS_ASSERT_NEXT(a_div_to_out, clk_i, rst_ni, div_done && state_q == S_DIV, out_valid_o)

endmodule

/* tb/cramer_rule_linear_solver_core_tb.sv */
// testbench for the cramer rule solver: directed table, random systems, predicted solutions
`timescale 1ns / 1ps
module cramer_rule_linear_solver_core_tb;

  localparam int N_MAX = 4;
  localparam int FRAC = 16;
  localparam int SOLW = crls_pkg::SOL_W;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic rhs;
    logic signed [11:0] val;
    logic last;
  } load_word_t;

  typedef struct packed {
    logic [1:0] idx;
    logic signed [SOLW-1:0] sol;
    logic sing;
    logic sat;
    logic lst;
  } sol_word_t;

  typedef struct {
    load_word_t w;
    logic has_exp;
    sol_word_t exp_res;
  } dir_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] row_index = 0;
  logic [1:0] col_index = 0;
  logic is_rhs = 0;
  logic signed [11:0] value = 0;
  logic last = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] unknown_index;
  logic signed [SOLW-1:0] solution;
  logic singular;
  logic saturated;
  logic last_result;

  cramer_rule_linear_solver_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .row_index_i(row_index), .col_index_i(col_index), .is_rhs_i(is_rhs),
    .value_i(value), .last_i(last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .unknown_index_o(unknown_index), .solution_o(solution), .singular_o(singular),
    .saturated_o(saturated), .last_result_o(last_result)
  );

  longint coef_m [N_MAX][N_MAX];
  longint rhs_v [N_MAX];
  int size_reg;
  sol_word_t solution_q [$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic longint det_n(input longint m [N_MAX][N_MAX], input int n);
    longint mn [N_MAX][N_MAX];
    longint acc;
    int mc;
    acc = 0;
    if (n == 1) return m[0][0];
    for (int c = 0; c < n; c++) begin
      for (int r = 1; r < n; r++) begin
        mc = 0;
        for (int k = 0; k < n; k++) begin
          if (k != c) begin
            mn[r-1][mc] = m[r][k];
            mc++;
          end
        end
      end
      if (c & 1) acc -= m[0][c] * det_n(mn, n - 1);
      else acc += m[0][c] * det_n(mn, n - 1);
    end
    return acc;
  endfunction

  function automatic logic [SOLW:0] fixed_divide(input longint num, input longint den);
    longint unsigned a, d, lim, q0, r, frac, q;
    logic neg, sat;
    a = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    lim = neg ? (64'd1 << (SOLW - 1)) : ((64'd1 << (SOLW - 1)) - 1);
    q0 = a / d;
    r = a % d;
    frac = 0;
    sat = 0;
    if (q0 > (lim >> FRAC)) begin
      q = lim;
      sat = 1;
    end else begin
      for (int i = 0; i < FRAC; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= d) begin
          r -= d;
          frac |= 1;
        end
      end
      q = (q0 << FRAC) | frac;
      if (q > lim) begin
        q = lim;
        sat = 1;
      end
    end
    if (neg) q = -q;
    return {sat, q[SOLW-1:0]};
  endfunction

  // store the word and, on last, queue the solution words
  task automatic solve_word(input load_word_t w);
    longint work [N_MAX][N_MAX];
    longint dm;
    int n;
    logic [SOLW:0] dq;
    sol_word_t s;
    if (w.rhs) rhs_v[w.row] = w.val;
    else coef_m[w.row][w.col] = w.val;
    if (!w.last) return;
    n = size_reg < 1 ? 1 : (size_reg > N_MAX ? N_MAX : size_reg);
    dm = det_n(coef_m, n);
    if (dm == 0) begin
      s = '{idx: 0, sol: 0, sing: 1, sat: 0, lst: 1};
      solution_q.push_back(s);
      return;
    end
    for (int i = 0; i < n; i++) begin
      work = coef_m;
      for (int j = 0; j < n; j++) work[j][i] = rhs_v[j];
      dq = fixed_divide(det_n(work, n), dm);
      s = '{idx: i[1:0], sol: dq[SOLW-1:0], sing: 0, sat: dq[SOLW], lst: i == n - 1};
      solution_q.push_back(s);
    end
  endtask

  function automatic int gap_len();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) g = 0;
    return g;
  endfunction

  // in_valid stays high after acceptance only when the next word follows at once
  task automatic send_word(input load_word_t w, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    row_index <= w.row;
    col_index <= w.col;
    is_rhs <= w.rhs;
    value <= w.val;
    last <= w.last;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    solve_word(w);
  endtask

  task automatic stop_words();
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic write_size(input int sz);
    stop_words();
    while (solution_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data <= sz[2:0];
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    size_reg = sz;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // full random system of size n; rows may be loaded in any order
  task automatic random_system(input int n, input bit extreme);
    load_word_t ws [$];
    load_word_t w;
    int k;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        w = '{row: r[1:0], col: c[1:0], rhs: 0, val: 12'($urandom), last: 0};
        if (!extreme && $urandom_range(0, 1))
          w.val = 12'(int'($urandom_range(0, 40)) - 20);
        ws.push_back(w);
      end
      w = '{row: r[1:0], col: 2'($urandom), rhs: 1, val: 12'($urandom), last: 0};
      ws.push_back(w);
    end
    ws.shuffle();
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, ws.size() - 1);
      ws.push_back(ws[k]);
      ws[ws.size()-1].val = 12'($urandom);
    end
    ws[ws.size()-1].last = 1;
    foreach (ws[i]) send_word(ws[i], 1);
  endtask

  task automatic fill_all(input logic signed [11:0] v);
    load_word_t w;
    for (int r = 0; r < N_MAX; r++) begin
      for (int c = 0; c < N_MAX; c++) begin
        w = '{row: r[1:0], col: c[1:0], rhs: 0, val: (r == c) ? v : 12'sd0, last: 0};
        send_word(w, 0);
      end
      w = '{row: r[1:0], col: 0, rhs: 1, val: v, last: 0};
      send_word(w, 0);
    end
  endtask

  always @(posedge clk) begin
    sol_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (solution_q.size() == 0) report("result word with none expected");
      else begin
        e = solution_q.pop_front();
        if (unknown_index !== e.idx) report($sformatf("index %0d exp %0d", unknown_index, e.idx));
        if (solution !== e.sol) report($sformatf("solution %0d exp %0d", solution, e.sol));
        if (singular !== e.sing) report($sformatf("singular %b exp %b", singular, e.sing));
        if (saturated !== e.sat) report($sformatf("saturated %b exp %b", saturated, e.sat));
        if (last_result !== e.lst) report($sformatf("last %b exp %b", last_result, e.lst));
      end
    end
  end

  // receiver with random stalls and one long hold off
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        out_ready <= 0;
        repeat (g - 1) @(negedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  initial begin
    dir_row_t tbl [$];
    dir_row_t d;
    longint wait_cnt;
    size_reg = 3;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // identity of size 4 with extreme rhs, then singular
    fill_all(12'sd1);
    write_size(4);
    d.has_exp = 0;
    d.w = '{row: 3, col: 0, rhs: 1, val: -12'sd2048, last: 0}; tbl.push_back(d);
    d.w = '{row: 0, col: 2, rhs: 1, val: 12'sd2047, last: 0}; tbl.push_back(d);
    d.w = '{row: 3, col: 3, rhs: 0, val: 12'sd1, last: 1}; tbl.push_back(d);
    d.w = '{row: 2, col: 2, rhs: 0, val: 12'sd0, last: 1}; d.has_exp = 1;
    d.exp_res = '{idx: 0, sol: 0, sing: 1, sat: 0, lst: 1}; tbl.push_back(d);
    d.has_exp = 0;
    foreach (tbl[i]) begin
      send_word(tbl[i].w, 0);
      if (tbl[i].has_exp && tbl[i].exp_res !== solution_q[$]) report("directed row");
    end
    write_size(1);
    send_word('{row: 0, col: 0, rhs: 0, val: 12'sd1, last: 0}, 0);
    send_word('{row: 0, col: 3, rhs: 1, val: 12'sd2047, last: 1}, 0);
    send_word('{row: 0, col: 0, rhs: 0, val: -12'sd2048, last: 1}, 0);
    send_word('{row: 0, col: 1, rhs: 0, val: 12'sd5, last: 1}, 0);
    write_size(0);
    send_word('{row: 0, col: 0, rhs: 0, val: -12'sd1, last: 1}, 0);
    write_size(7);
    send_word('{row: 3, col: 3, rhs: 0, val: 12'sd3, last: 1}, 0);
    write_size(2);
    send_word('{row: 1, col: 0, rhs: 0, val: 12'sd0, last: 0}, 0);
    send_word('{row: 0, col: 1, rhs: 0, val: 12'sd0, last: 0}, 0);
    send_word('{row: 1, col: 1, rhs: 0, val: 12'sd7, last: 1}, 0);

    // long receiver stall, during which loading waits for the results to be taken
    hold_off = 1;
    random_system(2, 0);
    send_word('{row: 0, col: 0, rhs: 1, val: 12'sd9, last: 1}, 0);

    for (int p = 0; p < 4; p++) begin
      write_size(p == 3 ? 4 : p + 1);
      for (int s = 0; s < (p == 3 ? 2 : 3); s++) random_system(size_reg, s == 0);
    end
    write_size(3);
    for (int s = 0; s < 1; s++) random_system(3, 0);

    stop_words();
    wait_cnt = 0;
    while (solution_q.size() != 0 && wait_cnt < 500000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && solution_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/crls_pkg.sv
sv/crls_div.sv
sv/cramer_rule_linear_solver_core.sv
tb/cramer_rule_linear_solver_core_tb.sv
